### rtl/core/fscl_pkg.sv
`default_nettype none

package fscl_pkg;

    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 8;
    localparam int unsigned S_TDATA_W    = 16;
    localparam int unsigned M_TDATA_W    = 8;
    localparam int unsigned RUN_CNT_W    = 6;

    localparam logic [2:0] TARGET_RESET    = 3'd1;
    localparam logic [7:0] WAIT_LIMIT_RESET = 8'd250;
    localparam logic [5:0] TRAILING_RESET  = 6'd16;
    localparam logic [3:0] ATTEMPTS_RESET  = 4'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_SELECT   = 2'd0,
        CFG_DONE_WAIT_LIMIT = 2'd1,
        CFG_TRAILING_CLOCKS = 2'd2,
        CFG_MAX_ATTEMPTS    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_SEND  = 2'd0,
        PH_START = 2'd1,
        PH_OK    = 2'd2,
        PH_FAIL  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY       = 3'd0,
        ST_INIT_ERROR = 3'd1,
        ST_CONFIGURED = 3'd2,
        ST_RETRY      = 3'd3,
        ST_GAVE_UP    = 3'd4,
        ST_IGNORED    = 3'd5
    } status_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        TGT_DEV1 = 3'd1,
        TGT_DEV2 = 3'd2,
        TGT_DEV3 = 3'd3,
        TGT_DEV4 = 3'd4,
        TGT_PAIR = 3'd5
    } target_t;

    function automatic logic [3:0] watch_mask(input logic [2:0] target);
        logic [3:0] mask;
        begin
            case (target)
                TGT_DEV1: mask = 4'b0001;
                TGT_DEV2: mask = 4'b0010;
                TGT_DEV3: mask = 4'b0100;
                TGT_DEV4: mask = 4'b1000;
                TGT_PAIR: mask = 4'b0011;
                default:  mask = 4'b0001;
            endcase
            return mask;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/fpga_serial_config_loader.sv
// Each accepted item is loaded into the run counter registers, and each of its results is then registered
// into the output stage. The run counter gives one pulse per cycle while the output is free or taken;
// a byte item gives 8 results (1 if ignored), a tick item 1, or 1 + trailing_clocks when it ends the startup.
// The next item is taken in the cycle the last result of the current one leaves the counter.
// Reset (rst_n low, asynchronous) clears the load state and the run, and restores the
// register defaults: target 1, wait limit 250, 16 trailing pulses, 2 attempts.
`default_nettype none

module fpga_serial_config_loader
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    // configuration write channel
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire  [fscl_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire  [fscl_pkg::CFG_DATA_W-1:0]         cfg_data,
    // input items
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    input  wire  [fscl_pkg::S_TDATA_W-1:0]          s_tdata, // data_byte[7:0], init_levels[11:8], done_levels[15:12]
    input  wire                                     s_tuser, // req_type
    // result items
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    output logic [fscl_pkg::M_TDATA_W-1:0]          m_tdata, // din_bit[0], cclk_pulse[1], status[4:2], zero[7:5]
    output logic                                    m_tlast  // last_of_run
);

    import fscl_pkg::*;

    logic [2:0]             target_reg;
    logic [7:0]             wait_limit_reg;
    logic [5:0]             trailing_reg;
    logic [3:0]             max_att_reg;

    phase_t                 phase_reg, phase_next;
    logic                   init_err_reg, init_err_next;
    logic [7:0]             tick_reg, tick_next;
    logic [3:0]             att_reg, att_next;

    logic                   job_active_reg;
    logic [7:0]             job_shift_reg, job_shift_next;
    logic [RUN_CNT_W-1:0]   job_cnt_reg, job_cnt_next;
    logic                   job_clk_reg, job_clk_next;
    status_t                job_status_reg, job_status_next;

    logic                   out_valid_reg;
    logic                   out_din_reg;
    logic                   out_clk_reg;
    logic                   out_last_reg;
    status_t                out_status_reg;

    logic                   job_emit;
    logic                   job_final;
    logic                   in_accept;

    logic [7:0]             in_byte;
    logic [3:0]             in_init;
    logic [3:0]             in_done;
    logic [3:0]             mask;
    logic                   byte_ignored;
    logic                   tick_ignored;
    logic                   init_bad;
    logic                   done_ok;
    logic                   at_limit;
    logic                   run_end;
    logic [7:0]             tick_inc;
    logic [3:0]             att_inc;
    logic                   give_up;

    assign in_byte = s_tdata[7:0];
    assign in_init = s_tdata[11:8];
    assign in_done = s_tdata[15:12];

    assign cfg_ready = 1'b1;

    assign job_emit  = job_active_reg && (!out_valid_reg || m_tready);
    assign job_final = job_emit && (job_cnt_reg == '0);
    assign s_tready  = !job_active_reg || job_final;
    assign in_accept = s_tvalid && s_tready;

    assign mask         = watch_mask(target_reg);
    assign byte_ignored = (phase_reg != PH_SEND) || init_err_reg;
    assign tick_ignored = (phase_reg == PH_OK) || (phase_reg == PH_FAIL);
    assign init_bad     = (in_init & mask) != mask;
    assign done_ok      = (in_done & mask) == mask;
    assign tick_inc     = tick_reg + 8'd1;
    assign at_limit     = tick_inc >= wait_limit_reg;
    assign run_end      = done_ok || at_limit;
    assign att_inc      = att_reg + 4'd1;
    assign give_up      = att_inc >= max_att_reg;

    // next load state
    always_comb
    begin
        phase_next    = phase_reg;
        init_err_next = init_err_reg;
        tick_next     = tick_reg;
        att_next      = att_reg;
        if (s_tuser == REQ_BYTE)
        begin
            if (!byte_ignored && init_bad)
            begin
                init_err_next = 1'b1;
            end
        end
        else if (!tick_ignored)
        begin
            phase_next = PH_START;
            tick_next  = tick_inc;
            if (done_ok)
            begin
                phase_next = PH_OK;
            end
            else if (at_limit)
            begin
                att_next = att_inc;
                if (give_up)
                begin
                    phase_next = PH_FAIL;
                end
                else
                begin
                    phase_next    = PH_SEND;
                    init_err_next = 1'b0;
                    tick_next     = 8'd0;
                end
            end
        end
    end

    // run setup for the accepted item
    always_comb
    begin
        job_shift_next  = 8'd0;
        job_cnt_next    = '0;
        job_clk_next    = 1'b1;
        job_status_next = ST_BUSY;
        if (s_tuser == REQ_BYTE)
        begin
            if (byte_ignored)
            begin
                job_clk_next    = 1'b0;
                job_status_next = ST_IGNORED;
            end
            else
            begin
                job_shift_next  = in_byte;
                job_cnt_next    = RUN_CNT_W'(7);
                job_status_next = init_bad ? ST_INIT_ERROR : ST_BUSY;
            end
        end
        else if (tick_ignored)
        begin
            job_clk_next    = 1'b0;
            job_status_next = ST_IGNORED;
        end
        else if (run_end)
        begin
            job_cnt_next = trailing_reg;
            if (done_ok)
            begin
                job_status_next = ST_CONFIGURED;
            end
            else
            begin
                job_status_next = give_up ? ST_GAVE_UP : ST_RETRY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= TARGET_RESET;
            wait_limit_reg <= WAIT_LIMIT_RESET;
            trailing_reg   <= TRAILING_RESET;
            max_att_reg    <= ATTEMPTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TARGET_SELECT:   target_reg     <= cfg_data[2:0];
                CFG_DONE_WAIT_LIMIT: wait_limit_reg <= cfg_data[7:0];
                CFG_TRAILING_CLOCKS: trailing_reg   <= cfg_data[5:0];
                CFG_MAX_ATTEMPTS:    max_att_reg    <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEND;
            init_err_reg <= 1'b0;
            tick_reg     <= 8'd0;
            att_reg      <= 4'd0;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            init_err_reg <= init_err_next;
            tick_reg     <= tick_next;
            att_reg      <= att_next;
        end
    end

    // run counter: one pulse per cycle while the output is free or taken, load a new item as the last one leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_active_reg <= 1'b0;
            job_cnt_reg    <= '0;
            job_shift_reg  <= 8'd0;
            job_clk_reg    <= 1'b0;
            job_status_reg <= ST_BUSY;
        end
        else if (in_accept)
        begin
            job_active_reg <= 1'b1;
            job_cnt_reg    <= job_cnt_next;
            job_shift_reg  <= job_shift_next;
            job_clk_reg    <= job_clk_next;
            job_status_reg <= job_status_next;
        end
        else if (job_final)
        begin
            job_active_reg <= 1'b0;
        end
        else if (job_emit)
        begin
            job_cnt_reg   <= job_cnt_reg - RUN_CNT_W'(1);
            job_shift_reg <= {job_shift_reg[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (job_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_emit)
        begin
            out_din_reg    <= job_shift_reg[7];
            out_clk_reg    <= job_clk_reg;
            out_last_reg   <= job_cnt_reg == '0;
            out_status_reg <= (job_cnt_reg == '0) ? job_status_reg : ST_BUSY;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_status_reg, out_clk_reg, out_din_reg};

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_status_reg == ST_BUSY)
        else $error("non-final result carries a status");

    a_ignored_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_IGNORED |-> !out_clk_reg && !out_din_reg
            && out_last_reg)
        else $error("ignored item issued a pulse");

    a_ok_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_OK |=> phase_reg == PH_OK)
        else $error("configured phase left");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAIL |=> phase_reg == PH_FAIL)
        else $error("gave-up phase left");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !job_active_reg |-> job_cnt_reg == '0)
        else $error("run count left over with no item in progress");

endmodule

`default_nettype wire

### tb/fpga_serial_config_loader_tb.sv
`timescale 1ns / 100ps

module fpga_serial_config_loader_tb;

    import fscl_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS_PER_PASS = 54;

    typedef struct packed {
        logic    din;
        logic    clk_pulse;
        logic    tail;
        status_t status;
    } pulse_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_TARGET_SELECT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = REQ_BYTE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    // mirror of the loader registers and load state
    logic [2:0]             tgt_sel = TARGET_RESET;
    logic [7:0]             wait_lim = WAIT_LIMIT_RESET;
    logic [5:0]             trail_cnt = TRAILING_RESET;
    logic [3:0]             attempt_max = ATTEMPTS_RESET;
    phase_t                 ld_phase = PH_SEND;
    logic                   init_err = 1'b0;
    logic [7:0]             tick_cnt = '0;
    logic [3:0]             fail_cnt = '0;

    pulse_t                 pulse_expect_q[$];
    int unsigned            src_idle_pct = 0;
    int unsigned            sink_stall_pct = 0;
    int unsigned            err_cnt = 0;
    int unsigned            items_sent = 0;
    int unsigned            pulses_seen = 0;
    int unsigned            retries_seen = 0;
    int unsigned            cfg_writes = 0;
    int unsigned            quiet_cycles = 0;

    fpga_serial_config_loader u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [3:0] lines_watched(input logic [2:0] target);
        case (target)
            TGT_DEV1, TGT_DEV2, TGT_DEV3, TGT_DEV4: return 4'b0001 << (target - TGT_DEV1);
            TGT_PAIR: return 4'b0011;
            default:  return 4'b0001;
        endcase
    endfunction

    // pull one watched line low if all of them are high
    function automatic logic [3:0] break_lines(input logic [3:0] lines, input logic [3:0] mask);
        if ((lines & mask) == mask)
        begin
            return lines & ~(mask & (~mask + 4'd1));
        end
        return lines;
    endfunction

    function automatic void push_pulse(input logic din, input logic pulse, input logic tail,
                                       input status_t status);
        pulse_t p;
        p.din       = din;
        p.clk_pulse = pulse;
        p.tail      = tail;
        p.status    = status;
        pulse_expect_q.push_back(p);
    endfunction

    function automatic void predict_load_step(input req_type_t kind, input logic [7:0] data_byte,
                                              input logic [3:0] init_lines,
                                              input logic [3:0] done_lines);
        logic [3:0] mask;
        status_t    fin;
        logic       is_done;
        logic       at_limit;
        mask = lines_watched(tgt_sel);
        if (kind == REQ_BYTE)
        begin
            if (ld_phase != PH_SEND || init_err)
            begin
                push_pulse(1'b0, 1'b0, 1'b1, ST_IGNORED);
                return;
            end
            fin = ST_BUSY;
            if ((init_lines & mask) != mask)
            begin
                init_err = 1'b1;
                fin = ST_INIT_ERROR;
            end
            for (int i = 0; i < 8; i++)
            begin
                push_pulse(data_byte[7-i], 1'b1, i == 7, (i == 7) ? fin : ST_BUSY);
            end
            return;
        end
        if (ld_phase == PH_OK || ld_phase == PH_FAIL)
        begin
            push_pulse(1'b0, 1'b0, 1'b1, ST_IGNORED);
            return;
        end
        ld_phase = PH_START;
        tick_cnt = tick_cnt + 8'd1;
        is_done  = (done_lines & mask) == mask;
        at_limit = tick_cnt >= wait_lim;
        if (!is_done && !at_limit)
        begin
            push_pulse(1'b0, 1'b1, 1'b1, ST_BUSY);
            return;
        end
        if (is_done)
        begin
            fin = ST_CONFIGURED;
            ld_phase = PH_OK;
        end
        else
        begin
            fail_cnt = fail_cnt + 4'd1;
            if (fail_cnt >= attempt_max)
            begin
                fin = ST_GAVE_UP;
                ld_phase = PH_FAIL;
            end
            else
            begin
                fin = ST_RETRY;
                ld_phase = PH_SEND;
                init_err = 1'b0;
                tick_cnt = '0;
                retries_seen++;
            end
        end
        for (int i = 0; i <= int'(trail_cnt); i++)
        begin
            push_pulse(1'b0, 1'b1, i == int'(trail_cnt), (i == int'(trail_cnt)) ? fin : ST_BUSY);
        end
    endfunction

    function automatic void compare_field(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            err_cnt++;
            if (err_cnt <= 40)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            end
        end
    endfunction

    task automatic send_item(input req_type_t kind, input logic [7:0] data_byte,
                             input logic [3:0] init_lines, input logic [3:0] done_lines);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {done_lines, init_lines, data_byte};
        do @(posedge clk); while (!s_tready);
        predict_load_step(kind, data_byte, init_lines, done_lines);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pulse_expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cfg_writes++;
        case (idx)
            CFG_TARGET_SELECT:   tgt_sel = value[2:0];
            CFG_DONE_WAIT_LIMIT: wait_lim = value;
            CFG_TRAILING_CLOCKS: trail_cnt = value[5:0];
            CFG_MAX_ATTEMPTS:    attempt_max = value[3:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        cfg_write(CFG_DONE_WAIT_LIMIT, 8'd2);
        send_item(REQ_BYTE, 8'h00, 4'hF, 4'h0);
        send_item(REQ_BYTE, 8'hFF, 4'b0001, 4'h0);
        send_item(REQ_BYTE, 8'h80, 4'hF, 4'hF);
        send_item(REQ_BYTE, 8'h01, 4'hF, 4'h0);
        send_item(REQ_TICK, 8'h00, 4'h0, 4'h0);
        send_item(REQ_BYTE, 8'hA5, 4'hF, 4'h0);
        send_item(REQ_TICK, 8'hFF, 4'hF, 4'b1110);
        wait_drained();
    endtask

    task automatic test_init_error();
        cfg_write(CFG_MAX_ATTEMPTS, 8'h0F);
        send_item(REQ_BYTE, 8'h5A, 4'b1110, 4'h0);
        send_item(REQ_BYTE, 8'hC3, 4'hF, 4'h0);
        send_item(REQ_TICK, 8'h00, 4'hF, 4'h0);
        send_item(REQ_TICK, 8'h00, 4'hF, 4'b0110);
        wait_drained();
    endtask

    task automatic test_target_lines();
        for (int t = 0; t < 8; t++)
        begin
            cfg_write(CFG_TARGET_SELECT, 8'(t));
            send_item(REQ_BYTE, 8'($urandom), lines_watched(tgt_sel), 4'h0);
            wait_drained();
        end
        cfg_write(CFG_TARGET_SELECT, 8'(TGT_PAIR));
        send_item(REQ_BYTE, 8'($urandom), 4'b1101, 4'h0);
        send_item(REQ_TICK, 8'h00, 4'hF, 4'b1101);
        wait_drained();
    endtask

    task automatic test_zero_wait_no_trailing();
        cfg_write(CFG_DONE_WAIT_LIMIT, 8'd0);
        cfg_write(CFG_TRAILING_CLOCKS, 8'd0);
        send_item(REQ_TICK, 8'h00, 4'hF, 4'h0);
        send_item(REQ_TICK, 8'h00, 4'hF, 4'h2);
        wait_drained();
    endtask

    task automatic test_random_load(input int unsigned idle_src, input int unsigned idle_sink,
                                    input logic [7:0] wait_val, input logic [5:0] trail_val,
                                    input logic [3:0] retry_cap);
        int unsigned counted;
        logic [3:0]  mask;
        logic [3:0]  init_lines;
        logic [3:0]  done_lines;
        logic        sending;
        logic        ticks_ok;
        logic        stuck;
        src_idle_pct   = idle_src;
        sink_stall_pct = idle_sink;
        cfg_write(CFG_TARGET_SELECT, {5'($urandom), 3'($urandom_range(0, 7))});
        cfg_write(CFG_DONE_WAIT_LIMIT, wait_val);
        cfg_write(CFG_TRAILING_CLOCKS, {2'($urandom), trail_val});
        cfg_write(CFG_MAX_ATTEMPTS, {4'($urandom), 4'hF});
        mask    = lines_watched(tgt_sel);
        counted = 0;
        stuck   = 1'b0;
        while (counted < RANDOM_ITEMS_PER_PASS && !stuck)
        begin
            sending    = (ld_phase == PH_SEND) && !init_err;
            // hold off a retry once this pass has used its share of attempts
            ticks_ok   = (int'(tick_cnt) + 1 < int'(wait_lim)) || (fail_cnt < retry_cap);
            init_lines = 4'($urandom);
            done_lines = break_lines(4'($urandom), mask);
            if (sending && (!ticks_ok || $urandom_range(0, 99) < 80))
            begin
                if ($urandom_range(0, 99) < 8 && fail_cnt < retry_cap)
                begin
                    init_lines = break_lines(init_lines, mask);
                end
                else
                begin
                    init_lines = init_lines | mask;
                end
                send_item(REQ_BYTE, 8'($urandom), init_lines, done_lines);
                counted++;
            end
            else if (!sending && $urandom_range(0, 99) < 8)
            begin
                send_item(REQ_BYTE, 8'($urandom), init_lines, done_lines);
            end
            else if (ticks_ok)
            begin
                send_item(REQ_TICK, 8'($urandom), init_lines, done_lines);
                counted++;
            end
            else
            begin
                stuck = 1'b1;
            end
        end
        wait_drained();
    endtask

    task automatic test_load_end();
        logic [3:0] mask;
        src_idle_pct   = 25;
        sink_stall_pct = 25;
        if ($urandom_range(0, 1) == 1)
        begin
            cfg_write(CFG_TRAILING_CLOCKS, {2'($urandom), 6'h3F});
            mask = lines_watched(tgt_sel);
            if (ld_phase == PH_SEND && !init_err)
            begin
                send_item(REQ_BYTE, 8'($urandom), break_lines(4'($urandom), mask), 4'h0);
            end
            send_item(REQ_TICK, 8'($urandom), 4'($urandom), 4'($urandom) | mask);
        end
        else
        begin
            cfg_write(CFG_MAX_ATTEMPTS, {4'($urandom), 4'h0});
            cfg_write(CFG_DONE_WAIT_LIMIT, 8'd0);
            mask = lines_watched(tgt_sel);
            send_item(REQ_TICK, 8'($urandom), 4'($urandom), break_lines(4'($urandom), mask));
        end
        for (int i = 0; i < 6; i++)
        begin
            send_item(req_type_t'($urandom_range(0, 1)), 8'($urandom), 4'($urandom),
                      4'($urandom));
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        pulse_t want;
        if (m_tvalid && m_tready)
        begin
            pulses_seen++;
            if (pulse_expect_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 40)
                begin
                    $display("%0t: unexpected result, expected none, got tdata %0h tlast %0b",
                             $time, m_tdata, m_tlast);
                end
            end
            else
            begin
                want = pulse_expect_q.pop_front();
                compare_field("din_bit", 8'(want.din), 8'(m_tdata[0]));
                compare_field("cclk_pulse", 8'(want.clk_pulse), 8'(m_tdata[1]));
                compare_field("status", 8'(want.status), 8'(m_tdata[4:2]));
                compare_field("tdata pad", 8'h00, 8'(m_tdata[7:5]));
                compare_field("last_of_run", 8'(want.tail), 8'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_init_error();
        test_target_lines();
        test_zero_wait_no_trailing();
        test_random_load(0, 0, 8'($urandom_range(10, 40)), 6'd63, 4'd6);
        test_random_load(53, 0, 8'd1, 6'($urandom_range(0, 63)), 4'd9);
        test_random_load(0, 53, 8'd255, 6'd0, 4'd12);
        test_random_load(25, 25, 8'($urandom_range(0, 12)), 6'($urandom), 4'd14);
        test_load_end();
        repeat (5) @(posedge clk);
        $display("Sent %0d items through %0d register writes; checked %0d pulses.",
                 items_sent, cfg_writes, pulses_seen);
        $display("Load went through %0d retries and ended in phase %s.",
                 retries_seen, ld_phase.name());
        if (err_cnt == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
